// ===== rtl/grid_cell_index_3d_macros.svh =====
// assertion macros for the grid cell index block
`ifndef GRID_CELL_INDEX_3D_MACROS_SVH
`define GRID_CELL_INDEX_3D_MACROS_SVH
// implication checked every clock outside reset
`define GCI_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define GCI_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/gci_pkg.sv =====
// shared types and constants for the grid cell index block
`timescale 1ns / 1ps
package gci_pkg;
  localparam int unsigned IndexWidth = 31;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxWidth = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_X_LOW = 3'd0,
    REG_X_HIGH = 3'd1,
    REG_Y_LOW = 3'd2,
    REG_Y_HIGH = 3'd3,
    REG_Z_LOW = 3'd4,
    REG_Z_HIGH = 3'd5,
    REG_COUNTS = 3'd6,
    REG_MODE = 3'd7
  } cfg_reg_e;
endpackage

// ===== rtl/gci_div_cell.sv =====
// one restoring division step cell, registered, with side-band passing
`timescale 1ns / 1ps
module gci_div_cell import gci_pkg::*; #(
  parameter int unsigned DW = 42,
  parameter int unsigned VW = 33,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [VW-1:0] rem_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  input  logic [DW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [VW-1:0] rem_o,
  output logic [DW-1:0] num_o,
  output logic [VW-1:0] den_o,
  output logic [DW-1:0] quo_o,
  output logic [SW-1:0] side_o
);
  logic [VW:0] trial;
  logic [VW:0] diff;
  logic        take;

  assign trial = {rem_i, num_i[DW-1]};
  assign diff = trial - {1'b0, den_i};
  assign take = !diff[VW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? diff[VW-1:0] : trial[VW-1:0];
      num_o <= {num_i[DW-2:0], 1'b0};
      den_o <= den_i;
      quo_o <= {quo_i[DW-2:0], take};
      side_o <= side_i;
    end
  end
endmodule

// ===== rtl/gci_axis.sv =====
// per-axis front end and chain of division cells giving the cell number
`timescale 1ns / 1ps
module gci_axis import gci_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 10,
  parameter int unsigned SW = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [COORD_WIDTH-1:0] coord_i,
  input  logic signed [COORD_WIDTH-1:0] low_i,
  input  logic signed [COORD_WIDTH-1:0] high_i,
  input  logic [COUNT_WIDTH:0]          count_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          vld_o,
  output logic                          ok_o,
  output logic [COUNT_WIDTH-1:0]        cell_o,
  output logic [SW-1:0]                 side_o
);
  localparam int unsigned VW = COORD_WIDTH + 1;
  localparam int unsigned DW = VW + COUNT_WIDTH + 1;
  localparam int unsigned NC = DW;
  localparam int unsigned XW = SW + 2 + COUNT_WIDTH;

  // front stage registers: numerator, range and flags
  logic          f_vld_q;
  logic [DW-1:0] f_num_q;
  logic [VW-1:0] f_den_q;
  logic [XW-1:0] f_side_q;
  logic [VW-1:0] range_w;
  logic [VW-1:0] diff_w;
  logic          ok_w;
  logic          top_w;
  logic [DW-1:0] prod_w;

  assign range_w = VW'({high_i[COORD_WIDTH-1], high_i}) - VW'({low_i[COORD_WIDTH-1], low_i});
  assign diff_w = VW'({coord_i[COORD_WIDTH-1], coord_i}) - VW'({low_i[COORD_WIDTH-1], low_i});
  assign ok_w = (high_i > low_i) && (coord_i >= low_i) && (coord_i <= high_i);
  assign top_w = (coord_i == high_i);
  assign prod_w = DW'(diff_w) * DW'(count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en_i) begin
      f_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_num_q <= prod_w;
      f_den_q <= ok_w ? range_w : VW'(1);
      f_side_q <= {side_i, ok_w, top_w, COUNT_WIDTH'(count_i - 1'b1)};
    end
  end

  logic          c_vld [NC+1];
  logic [VW-1:0] c_rem [NC+1];
  logic [DW-1:0] c_num [NC+1];
  logic [VW-1:0] c_den [NC+1];
  logic [DW-1:0] c_quo [NC+1];
  logic [XW-1:0] c_side [NC+1];

  assign c_vld[0] = f_vld_q;
  assign c_rem[0] = '0;
  assign c_num[0] = f_num_q;
  assign c_den[0] = f_den_q;
  assign c_quo[0] = '0;
  assign c_side[0] = f_side_q;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    gci_div_cell #(.DW(DW), .VW(VW), .SW(XW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (c_vld[i]),
      .rem_i  (c_rem[i]),
      .num_i  (c_num[i]),
      .den_i  (c_den[i]),
      .quo_i  (c_quo[i]),
      .side_i (c_side[i]),
      .vld_o  (c_vld[i+1]),
      .rem_o  (c_rem[i+1]),
      .num_o  (c_num[i+1]),
      .den_o  (c_den[i+1]),
      .quo_o  (c_quo[i+1]),
      .side_o (c_side[i+1])
    );
  end

  logic [XW-1:0] last_side;
  logic [COUNT_WIDTH-1:0] last_cell;
  assign last_side = c_side[NC];
  assign last_cell = last_side[COUNT_WIDTH-1:0];

  assign vld_o = c_vld[NC];
  assign ok_o = last_side[COUNT_WIDTH+1];
  assign cell_o = last_side[COUNT_WIDTH] ? last_cell : c_quo[NC][COUNT_WIDTH-1:0];
  assign side_o = last_side[XW-1:COUNT_WIDTH+2];
endmodule

// ===== rtl/grid_cell_index_3d.sv =====
// top level: uniform 3d grid binning of points into 1-based cell indexes
// usage:
//   s_axis carries one point per beat: x, y, z signed fixed point coords.
//   m_axis returns one beat per point: cell index and outside flag.
//   registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while
//   idle; index order x low, x high, y low, y high, z low, z high, counts,
//   column major.
// pipeline: one front stage, one restoring division cell per quotient bit in
//   each axis chain, two index multiply stages and the output register.
// throughput: one point per cycle while the output is not stalled; every
//   division cell takes a new point each cycle unless the pipeline freezes.
// reset: registers return to a unit grid with one cell per axis, pipeline
//   empties.
// stall: when m_axis_tready is low and the output holds a beat, the whole
//   pipeline freezes and s_axis_tready falls.
`timescale 1ns / 1ps
`include "grid_cell_index_3d_macros.svh"
module grid_cell_index_3d import gci_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned COUNT_WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [((COORD_WIDTH > 3 * COUNT_WIDTH) ? COORD_WIDTH : 3 * COUNT_WIDTH)-1:0]
                                   cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // x_coord, y_coord, z_coord
  input  logic [((3 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // cell_index, outside_grid
  output logic [31:0]              m_axis_tdata
);
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned NW = COUNT_WIDTH;

  logic signed [CW-1:0] low_q [3];
  logic signed [CW-1:0] high_q [3];
  logic [3*NW-1:0] counts_q;
  logic            colmaj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        low_q[a] <= '0;
        high_q[a] <= CW'(65536);
      end
      counts_q <= {NW'(1), NW'(1), NW'(1)};
      colmaj_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X_LOW:  low_q[0] <= cfg_wdata_i[CW-1:0];
        REG_X_HIGH: high_q[0] <= cfg_wdata_i[CW-1:0];
        REG_Y_LOW:  low_q[1] <= cfg_wdata_i[CW-1:0];
        REG_Y_HIGH: high_q[1] <= cfg_wdata_i[CW-1:0];
        REG_Z_LOW:  low_q[2] <= cfg_wdata_i[CW-1:0];
        REG_Z_HIGH: high_q[2] <= cfg_wdata_i[CW-1:0];
        REG_COUNTS: counts_q <= cfg_wdata_i[3*NW-1:0];
        REG_MODE:   colmaj_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [NW:0] cnt [3];
  for (genvar a = 0; a < 3; a++) begin : g_cnt
    assign cnt[a] = (counts_q[a*NW +: NW] == '0) ? {1'b1, NW'(0)} :
                    {1'b0, counts_q[a*NW +: NW]};
  end

  logic out_vld_q;
  logic en;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  logic          a_vld [3];
  logic          a_ok [3];
  logic [NW-1:0] a_cell [3];
  logic          a_side [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    gci_axis #(.COORD_WIDTH(CW), .COUNT_WIDTH(NW), .SW(1)) u_axis (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .vld_i   (s_axis_tvalid),
      .coord_i (s_axis_tdata[a*CW +: CW]),
      .low_i   (low_q[a]),
      .high_i  (high_q[a]),
      .count_i (cnt[a]),
      .side_i  (1'b0),
      .vld_o   (a_vld[a]),
      .ok_o    (a_ok[a]),
      .cell_o  (a_cell[a]),
      .side_o  (a_side[a])
    );
  end

  // index stage one: outer products
  localparam int unsigned PW = 2 * NW + 2;
  logic          m1_vld_q, m1_ok_q;
  logic [PW-1:0] m1_p_q, m1_q_q;
  logic [NW-1:0] m1_in_q;
  logic [PW-1:0] m1_stride_q;
  logic [NW:0]   n_in, n_mid;
  logic [NW-1:0] o_cell, m_cell, i_cell;

  assign n_in = colmaj_q ? cnt[2] : cnt[0];
  assign n_mid = cnt[1];
  assign o_cell = colmaj_q ? a_cell[0] : a_cell[2];
  assign m_cell = a_cell[1];
  assign i_cell = colmaj_q ? a_cell[2] : a_cell[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= a_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ok_q <= a_ok[0] && a_ok[1] && a_ok[2] && !a_side[0];
      m1_stride_q <= PW'(n_in) * PW'(n_mid);
      m1_p_q <= PW'(m_cell) * PW'(n_in);
      m1_q_q <= PW'(o_cell);
      m1_in_q <= i_cell;
    end
  end

  // index stage two
  localparam int unsigned IW = 3 * NW + 3;
  logic          m2_vld_q, m2_ok_q;
  logic [IW-1:0] m2_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_ok_q <= m1_ok_q;
      m2_idx_q <= IW'(m1_q_q) * IW'(m1_stride_q) + IW'(m1_p_q) + IW'(m1_in_q) + IW'(1);
    end
  end

  logic [IndexWidth-1:0] idx_q;
  logic                  outside_q;
  logic [IW+IndexWidth-1:0] idx_ext;
  assign idx_ext = {{IndexWidth{1'b0}}, m2_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q <= m2_ok_q ? idx_ext[IndexWidth-1:0] : '0;
      outside_q <= !m2_ok_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata = {outside_q, idx_q};

  `GCI_ASSERT_IMP(a_stall_ready, clk_i, rst_ni, out_vld_q && !m_axis_tready, !s_axis_tready)
  `GCI_ASSERT_NXT(a_hold_out, clk_i, rst_ni, out_vld_q && !m_axis_tready, out_vld_q && $stable(m_axis_tdata))
  `GCI_ASSERT_IMP(a_outside_zero, clk_i, rst_ni, out_vld_q && outside_q, idx_q == '0)
endmodule
